### rtl/av_pair_flag_setter_defines.svh
// assertion helpers shared by the rtl files
`ifndef AV_PAIR_FLAG_SETTER_DEFINES_SVH
`define AV_PAIR_FLAG_SETTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define AVPFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define AVPFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/avpfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package avpfs_pkg;

    localparam int MAX_LIST_BYTES = 4096;

    localparam int POS_W  = 13;
    localparam int NHP_W  = 17;
    localparam int IDX_W  = 4;

    // configuration register indexes
    localparam logic CFG_LIST_LENGTH = 1'b0;
    localparam logic CFG_OUTPUT_CAP  = 1'b1;

    localparam logic [15:0] ID_END     = 16'h0000;
    localparam logic [15:0] ID_FLAGS   = 16'h0006;
    localparam logic [15:0] LEN_FLAGS  = 16'h0004;
    localparam logic [7:0]  FLAG_MASK  = 8'h02;
    localparam logic [3:0]  PAIR_BEATS = 4'd8;

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_H1,
        PH_H2,
        PH_H3,
        PH_FLAG,
        PH_DONE
    } t_phase;

    // output beats caused by one input byte:
    // [pair if first] [byte0] [byte1] [pair if not first], or one error beat
    typedef struct packed {
        logic             err;
        logic             last;
        logic             pair_en;
        logic             pair_first;
        logic [1:0]       nbytes;
        logic [7:0]       byte0;
        logic [7:0]       byte1;
        logic [POS_W-1:0] total;
    } t_desc;

    // inserted pair: 06 00 04 00 02 00 00 00
    function automatic logic [7:0] pair_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = ID_FLAGS[7:0];
            3'd2:    v = LEN_FLAGS[7:0];
            3'd4:    v = FLAG_MASK;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/avpfs_parser.sv
`timescale 1ns / 1ps
`default_nettype none
`include "av_pair_flag_setter_defines.svh"
module avpfs_parser (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    input  wire                         i_ready,
    input  wire  [7:0]                  i_data,
    input  wire                         i_last,
    input  wire  [avpfs_pkg::POS_W-1:0] i_list_length,
    input  wire  [avpfs_pkg::POS_W-1:0] i_output_capacity,
    output logic                        o_push,
    output avpfs_pkg::t_desc            o_desc
);

    logic [avpfs_pkg::POS_W-1:0] r_pos, n_pos;
    logic [avpfs_pkg::NHP_W-1:0] r_nhp, n_nhp;
    logic [23:0]                 r_hb, n_hb;
    avpfs_pkg::t_phase           r_phase, n_phase;
    logic                        r_flags, n_flags;
    logic                        r_end, n_end;
    logic                        r_err, n_err;

    logic                        w_accept;
    logic [avpfs_pkg::POS_W-1:0] w_len;
    logic                        w_final;
    logic                        w_at_hdr;
    logic                        w_hdr_fits;
    logic [15:0]                 w_id;
    logic [15:0]                 w_hlen;
    logic [avpfs_pkg::POS_W-1:0] w_p;
    logic                        w_flag_pair;
    logic                        w_over;
    logic                        w_cap_err;
    logic                        w_end_hdr;
    logic                        w_step_err;
    logic                        w_new_end;
    logic                        w_new_flags;
    logic                        w_held;
    logic                        w_post_pair;
    logic                        w_hdr_phase;

    assign w_accept = i_valid && i_ready;

    always_comb begin
        if (i_list_length == '0) begin
            w_len = avpfs_pkg::POS_W'(1);
        end else if (32'(i_list_length) > avpfs_pkg::MAX_LIST_BYTES) begin
            w_len = avpfs_pkg::POS_W'(avpfs_pkg::MAX_LIST_BYTES);
        end else begin
            w_len = i_list_length;
        end
    end

    assign w_final    = i_last || (({1'b0, r_pos} + 14'd1) >= {1'b0, w_len});
    assign w_at_hdr   = ({4'b0, r_pos} == r_nhp);
    assign w_hdr_fits = (({1'b0, r_pos} + 14'd4) <= {1'b0, w_len});
    assign w_id       = {i_data, r_hb[7:0]};
    assign w_hlen     = {i_data, r_hb[23:16]};
    assign w_p        = r_pos - avpfs_pkg::POS_W'(3);
    assign w_flag_pair = (r_hb[15:0] == avpfs_pkg::ID_FLAGS)
                         && (w_hlen == avpfs_pkg::LEN_FLAGS)
                         && (({1'b0, w_p} + 14'd8) <= {1'b0, w_len});
    assign w_over     = (({1'b0, w_len} + 14'd8) > {1'b0, i_output_capacity});
    assign w_cap_err  = (r_pos == '0) && (w_len > i_output_capacity);

    // end header seen in this beat
    assign w_end_hdr  = !r_end && (r_phase == avpfs_pkg::PH_H1) && (w_id == avpfs_pkg::ID_END);
    assign w_step_err = w_end_hdr && !r_flags && w_over;
    assign w_new_end  = r_end || w_end_hdr;
    assign w_new_flags = r_flags || (!r_end && (r_phase == avpfs_pkg::PH_FLAG));
    // header start on the final byte: the held byte goes out as data
    assign w_held     = w_final && !r_end && (r_phase == avpfs_pkg::PH_SEEK)
                        && w_at_hdr && w_hdr_fits;
    assign w_post_pair = w_final && !w_new_end && !w_new_flags;
    assign w_hdr_phase = (r_phase == avpfs_pkg::PH_H2) || (r_phase == avpfs_pkg::PH_H3);

    // next state
    always_comb begin
        logic clear;
        clear   = 1'b0;
        n_pos   = r_pos;
        n_nhp   = r_nhp;
        n_hb    = r_hb;
        n_phase = r_phase;
        n_flags = r_flags;
        n_end   = r_end;
        n_err   = r_err;
        if (r_err) begin
            if (w_final) begin
                clear = 1'b1;
            end else begin
                n_pos = r_pos + avpfs_pkg::POS_W'(1);
            end
        end else if (w_cap_err || w_step_err) begin
            if (w_final) begin
                clear = 1'b1;
            end else begin
                n_err = 1'b1;
            end
        end else begin
            if (!r_end) begin
                case (r_phase)
                    avpfs_pkg::PH_SEEK: begin
                        if (w_at_hdr) begin
                            if (w_hdr_fits) begin
                                n_hb    = {16'h0000, i_data};
                                n_phase = avpfs_pkg::PH_H1;
                            end else begin
                                n_phase = avpfs_pkg::PH_DONE;
                            end
                        end
                    end
                    avpfs_pkg::PH_H1: begin
                        if (w_id == avpfs_pkg::ID_END) begin
                            n_end = 1'b1;
                        end else begin
                            n_hb    = {8'h00, w_id};
                            n_phase = avpfs_pkg::PH_H2;
                        end
                    end
                    avpfs_pkg::PH_H2: begin
                        n_hb    = {i_data, r_hb[15:0]};
                        n_phase = avpfs_pkg::PH_H3;
                    end
                    avpfs_pkg::PH_H3: begin
                        n_nhp   = {4'b0, w_p} + avpfs_pkg::NHP_W'(4) + {1'b0, w_hlen};
                        n_phase = w_flag_pair ? avpfs_pkg::PH_FLAG : avpfs_pkg::PH_SEEK;
                    end
                    avpfs_pkg::PH_FLAG: begin
                        n_flags = 1'b1;
                        n_phase = avpfs_pkg::PH_SEEK;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            if (w_final) begin
                clear = 1'b1;
            end else begin
                n_pos = r_pos + avpfs_pkg::POS_W'(1);
            end
        end
        if (clear) begin
            n_pos   = '0;
            n_nhp   = '0;
            n_hb    = '0;
            n_phase = avpfs_pkg::PH_SEEK;
            n_flags = 1'b0;
            n_end   = 1'b0;
            n_err   = 1'b0;
        end
    end

    // beats caused by this byte
    always_comb begin
        o_desc = '0;
        o_desc.nbytes = 2'd1;
        o_desc.byte0  = i_data;
        if (!r_end) begin
            case (r_phase)
                avpfs_pkg::PH_SEEK: begin
                    if (w_at_hdr && w_hdr_fits) begin
                        o_desc.nbytes = w_held ? 2'd1 : 2'd0;
                    end
                end
                avpfs_pkg::PH_H1: begin
                    o_desc.nbytes = 2'd2;
                    o_desc.byte0  = r_hb[7:0];
                    o_desc.byte1  = i_data;
                    if (w_end_hdr && !r_flags) begin
                        o_desc.pair_en    = 1'b1;
                        o_desc.pair_first = 1'b1;
                    end
                end
                avpfs_pkg::PH_FLAG: begin
                    o_desc.byte0 = i_data | avpfs_pkg::FLAG_MASK;
                end
                default: begin
                    o_desc.byte0 = i_data;
                end
            endcase
        end
        if (w_post_pair) begin
            o_desc.pair_en    = 1'b1;
            o_desc.pair_first = 1'b0;
        end
        o_desc.last  = w_final;
        o_desc.total = r_pos + avpfs_pkg::POS_W'(1)
                       + (w_new_flags ? avpfs_pkg::POS_W'(0) : avpfs_pkg::POS_W'(8));
        if (w_cap_err || w_step_err || (w_post_pair && w_over)) begin
            o_desc        = '0;
            o_desc.err    = 1'b1;
            o_desc.last   = 1'b1;
            o_desc.nbytes = 2'd0;
        end
        // a held header byte yields no beat until its id is known
        o_push = w_accept && !r_err
                 && (o_desc.err || o_desc.pair_en || (o_desc.nbytes != 2'd0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_nhp   <= '0;
            r_hb    <= '0;
            r_phase <= avpfs_pkg::PH_SEEK;
            r_flags <= 1'b0;
            r_end   <= 1'b0;
            r_err   <= 1'b0;
        end else if (w_accept) begin
            r_pos   <= n_pos;
            r_nhp   <= n_nhp;
            r_hb    <= n_hb;
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_end   <= n_end;
            r_err   <= n_err;
        end
    end

    `AVPFS_ASSERT_IMPL(a_hdr_id_nonzero, i_clk, i_rst_n,
        w_hdr_phase, r_hb[15:0] != avpfs_pkg::ID_END)
    `AVPFS_ASSERT_NEXT(a_final_clears, i_clk, i_rst_n,
        w_accept && w_final, (r_pos == '0) && !r_err && !r_end)

endmodule
`default_nettype wire

### rtl/avpfs_emitter.sv
`timescale 1ns / 1ps
`default_nettype none
`include "av_pair_flag_setter_defines.svh"
module avpfs_emitter (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_push,
    input  avpfs_pkg::t_desc            i_desc,
    output logic                        o_ready,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic [7:0]                  o_byte,
    output logic                        o_last,
    output logic                        o_status,
    output logic [avpfs_pkg::POS_W-1:0] o_total
);

    avpfs_pkg::t_desc            r_head, n_head;
    avpfs_pkg::t_desc            r_tail, n_tail;
    logic                        r_hv, n_hv;
    logic                        r_tv, n_tv;
    logic [avpfs_pkg::IDX_W-1:0] r_idx, n_idx;

    logic [avpfs_pkg::IDX_W-1:0] w_cnt;
    logic                        w_is_last;
    logic                        w_beat;
    logic                        w_pop;
    logic [avpfs_pkg::IDX_W-1:0] w_rel;

    assign o_ready = !r_tv;
    assign o_valid = r_hv;

    assign w_cnt = r_head.err ? avpfs_pkg::IDX_W'(1)
                 : ({2'b00, r_head.nbytes} + (r_head.pair_en ? avpfs_pkg::PAIR_BEATS : 4'd0));
    assign w_is_last = (r_idx == (w_cnt - avpfs_pkg::IDX_W'(1)));
    assign w_beat    = r_hv && i_ready;
    assign w_pop     = w_beat && w_is_last;
    // position past the leading bytes when the pair follows them
    assign w_rel     = r_idx - {2'b00, r_head.nbytes};

    always_comb begin
        o_byte   = 8'h00;
        o_last   = 1'b0;
        o_status = 1'b0;
        o_total  = '0;
        if (r_head.err) begin
            o_last   = 1'b1;
            o_status = 1'b1;
        end else begin
            if (r_head.pair_first) begin
                if (r_idx < avpfs_pkg::PAIR_BEATS) begin
                    o_byte = avpfs_pkg::pair_byte(r_idx[2:0]);
                end else begin
                    o_byte = r_idx[0] ? r_head.byte1 : r_head.byte0;
                end
            end else begin
                if (r_idx < {2'b00, r_head.nbytes}) begin
                    o_byte = r_idx[0] ? r_head.byte1 : r_head.byte0;
                end else begin
                    o_byte = avpfs_pkg::pair_byte(w_rel[2:0]);
                end
            end
            if (r_head.last && w_is_last) begin
                o_last  = 1'b1;
                o_total = r_head.total;
            end
        end
    end

    // two-entry descriptor queue
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_hv   = r_hv;
        n_tv   = r_tv;
        n_idx  = r_idx;
        if (w_beat) begin
            n_idx = w_is_last ? '0 : r_idx + avpfs_pkg::IDX_W'(1);
        end
        if (w_pop) begin
            if (r_tv) begin
                n_head = r_tail;
                if (i_push) begin
                    n_tail = i_desc;
                end else begin
                    n_tv = 1'b0;
                end
            end else if (i_push) begin
                n_head = i_desc;
            end else begin
                n_hv = 1'b0;
            end
        end else if (i_push) begin
            if (!r_hv) begin
                n_head = i_desc;
                n_hv   = 1'b1;
            end else begin
                n_tail = i_desc;
                n_tv   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
        if (!i_rst_n) begin
            r_hv  <= 1'b0;
            r_tv  <= 1'b0;
            r_idx <= '0;
        end else begin
            r_hv  <= n_hv;
            r_tv  <= n_tv;
            r_idx <= n_idx;
        end
    end

    `AVPFS_ASSERT_IMPL(a_tail_needs_head, i_clk, i_rst_n, r_tv, r_hv)
    `AVPFS_ASSERT_IMPL(a_idx_in_range, i_clk, i_rst_n, r_hv, r_idx < w_cnt)
    `AVPFS_ASSERT_NEXT(a_tail_moves_up, i_clk, i_rst_n, w_pop && r_tv, r_hv && (r_idx == '0))

endmodule
`default_nettype wire

### rtl/av_pair_flag_setter.sv
`timescale 1ns / 1ps
`default_nettype none
// Edits an attribute-value pair list streamed one byte per beat: the first value byte of a
// complete id-6, length-4 pair gets bit 1 set, and if no such pair appears an 8-byte
// pair (06 00 04 00 02 00 00 00) goes out before the id-0 end header, or after the last
// byte when there is none. Output beats carry the edited byte, tlast on the final beat
// of a list with the edited length beside it, and tuser set on the single error beat
// that ends a list exceeding output_capacity. Each input byte is parsed in the cycle it
// is accepted and leaves a descriptor in a two-entry queue, except the first byte of a
// header, which is held back until the next byte shows the id; the output sequencer
// drains one beat per cycle from the queue while the output is ready, so with one
// beat per byte the block sustains one byte per cycle; a byte that yields more beats
// (two for a header's second byte, up to 10 where the pair is inserted) holds the
// sequencer until its beats are out, and input stalls once both queue entries are full.
// Registers written on the configuration channel apply from the next accepted byte;
// there is no clearing pass after reset.
module av_pair_flag_setter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [12:0] i_cfg_data,
    // input byte stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire         i_s_axis_tlast,
    // output beat stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] out_byte, [20:8] total_length, [23:21] zero
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tuser    // [0] status
);

    logic [avpfs_pkg::POS_W-1:0] r_list_length;
    logic [avpfs_pkg::POS_W-1:0] r_output_capacity;

    logic                        w_push;
    avpfs_pkg::t_desc            w_desc;
    logic [7:0]                  w_byte;
    logic [avpfs_pkg::POS_W-1:0] w_total;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_length     <= avpfs_pkg::POS_W'(1);
            r_output_capacity <= avpfs_pkg::POS_W'(4104);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                avpfs_pkg::CFG_LIST_LENGTH: r_list_length     <= i_cfg_data;
                avpfs_pkg::CFG_OUTPUT_CAP:  r_output_capacity <= i_cfg_data;
                default:                    r_list_length     <= r_list_length;
            endcase
        end
    end

    avpfs_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_s_axis_tvalid),
        .i_ready           (o_s_axis_tready),
        .i_data            (i_s_axis_tdata),
        .i_last            (i_s_axis_tlast),
        .i_list_length     (r_list_length),
        .i_output_capacity (r_output_capacity),
        .o_push            (w_push),
        .o_desc            (w_desc)
    );

    avpfs_emitter u_emitter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_desc   (w_desc),
        .o_ready  (o_s_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_byte   (w_byte),
        .o_last   (o_m_axis_tlast),
        .o_status (o_m_axis_tuser),
        .o_total  (w_total)
    );

    assign o_m_axis_tdata = {3'b000, w_total, w_byte};

endmodule
`default_nettype wire
